FILE: rtl/es_descriptor_parser_core_defines.svh
// Assertion macros used by the checker in esdp_checker.sv.
`ifndef ES_DESCRIPTOR_PARSER_CORE_DEFINES_SVH
`define ES_DESCRIPTOR_PARSER_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ESDP_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ESDP_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/esdp_pkg.sv
`timescale 1ns / 1ps

package esdp_pkg;

   localparam int MAX_LENGTH_BYTES_DEF = 4;
   localparam int LEN_W = 28;
   localparam int ASM_W = 32;

   localparam logic [7:0] TAG_ES = 8'd3;
   localparam logic [7:0] TAG_DEC_CFG = 8'd4;
   localparam logic [7:0] TAG_DEC_SPEC = 8'd5;
   localparam logic [7:0] TAG_SL = 8'd6;
   localparam logic [LEN_W-1:0] SL_LENGTH = 28'd1;
   localparam logic [7:0] SL_PREDEFINED = 8'd2;
   localparam logic [LEN_W-1:0] CFG_BASE_SIZE = 28'd13;
   localparam logic [4:0] PRIORITY_RESET = 5'd16;

   localparam logic [LEN_W-1:0] ID_BYTES = 28'd2;
   localparam logic [LEN_W-1:0] BUF_BYTES = 28'd3;
   localparam logic [LEN_W-1:0] RATE_BYTES = 28'd4;

   typedef enum logic [4:0] {
      PH_TAG3, PH_ESLEN, PH_ESID, PH_FLAGS, PH_DEPID, PH_URLLEN, PH_URLSKIP,
      PH_OCR, PH_TAG4, PH_CFGLEN, PH_OBJ, PH_STYPE, PH_BUF, PH_MAXBR,
      PH_AVGBR, PH_TAG5, PH_CODLEN, PH_CODEC, PH_TAG6, PH_SLLEN, PH_SLPRE,
      PH_DONE
   } phase_type;

   typedef enum logic [3:0] {
      ST_OK, ST_TAG3, ST_TAG4, ST_RESERVED, ST_TAG5, ST_TAG6, ST_SL_LENGTH,
      ST_SL_PREDEFINED, ST_TRUNCATED
   } status_type;

   // Pending optional fields: bit 2 depends-on id, bit 1 URL, bit 0 OCR id.
   typedef struct packed {
      phase_type  phase;
      logic [2:0] flags;
      logic       start_field;
   } opt_type;

   typedef struct packed {
      logic        valid;
      logic        kind;
      logic [7:0]  codec_byte;
      logic [15:0] es_id;
      logic        depends_on_stream;
      logic [15:0] depends_es_id;
      logic [4:0]  stream_priority;
      logic [7:0]  object_type;
      logic [5:0]  stream_type;
      logic [23:0] buffer_size;
      logic [31:0] max_bitrate;
      logic [31:0] avg_bitrate;
      status_type  status;
   } result_type;

   function automatic opt_type next_optional(input logic [2:0] flags);
      opt_type r;
      r.flags = flags;
      r.start_field = 1'b0;
      if (flags[2]) begin
         r.flags[2] = 1'b0;
         r.phase = PH_DEPID;
         r.start_field = 1'b1;
      end else if (flags[1]) begin
         r.flags[1] = 1'b0;
         r.phase = PH_URLLEN;
      end else if (flags[0]) begin
         r.flags[0] = 1'b0;
         r.phase = PH_OCR;
         r.start_field = 1'b1;
      end else begin
         r.phase = PH_TAG4;
      end
      return r;
   endfunction

endpackage

FILE: rtl/esdp_phase_unit.sv
`timescale 1ns / 1ps

module esdp_phase_unit import esdp_pkg::*; #(
   parameter int MAX_LENGTH_BYTES = MAX_LENGTH_BYTES_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       advance,
   input  logic [7:0] data_byte,
   input  logic       is_last,
   output result_type result
);

   localparam int GW = $clog2(MAX_LENGTH_BYTES + 1);
   localparam logic [GW-1:0] MAX_GROUPS = GW'(MAX_LENGTH_BYTES);

   phase_type         phase_ff, phase_in;
   logic [LEN_W-1:0]  count_ff, count_in;
   logic [LEN_W-1:0]  accum_ff, accum_in;
   logic [GW-1:0]     groups_ff, groups_in;
   logic [2:0]        flags_ff, flags_in;
   logic              cfg_large_ff, cfg_large_in;
   logic [ASM_W-1:0]  asm_ff, asm_in;
   status_type        err_ff, err_in;
   logic [15:0]       es_id_ff, es_id_in;
   logic              dep_flag_ff, dep_flag_in;
   logic [15:0]       dep_id_ff, dep_id_in;
   logic [4:0]        prio_ff, prio_in;
   logic [7:0]        obj_ff, obj_in;
   logic [5:0]        stype_ff, stype_in;
   logic [23:0]       buf_ff, buf_in;
   logic [31:0]       maxbr_ff, maxbr_in;
   logic [31:0]       avgbr_ff, avgbr_in;

   logic [LEN_W-1:0]  accum_next;
   logic [GW-1:0]     groups_next;
   logic              len_done;
   logic [ASM_W-1:0]  asm_shift;
   logic [LEN_W-1:0]  count_dec;
   logic              field_done;
   logic              emit;
   opt_type           opt_new;
   opt_type           opt_pending;

   assign accum_next  = {accum_ff[LEN_W-8:0], data_byte[6:0]};
   assign groups_next = groups_ff + 1'b1;
   assign len_done    = !data_byte[7] || (groups_next >= MAX_GROUPS);
   assign asm_shift   = {asm_ff[ASM_W-9:0], data_byte};
   assign count_dec   = count_ff - 1'b1;
   assign field_done  = (count_dec == '0);
   assign opt_new     = next_optional(data_byte[7:5]);
   assign opt_pending = next_optional(flags_ff);

   always_comb begin
      phase_in = phase_ff;
      count_in = count_ff;
      accum_in = accum_ff;
      groups_in = groups_ff;
      flags_in = flags_ff;
      cfg_large_in = cfg_large_ff;
      asm_in = asm_ff;
      err_in = err_ff;
      es_id_in = es_id_ff;
      dep_flag_in = dep_flag_ff;
      dep_id_in = dep_id_ff;
      prio_in = prio_ff;
      obj_in = obj_ff;
      stype_in = stype_ff;
      buf_in = buf_ff;
      maxbr_in = maxbr_ff;
      avgbr_in = avgbr_ff;
      emit = 1'b0;

      case (phase_ff)
         PH_TAG3: begin
            if (data_byte != TAG_ES) begin
               err_in = ST_TAG3;
               phase_in = PH_DONE;
            end else begin
               accum_in = '0;
               groups_in = '0;
               phase_in = PH_ESLEN;
            end
         end
         PH_ESLEN: begin
            accum_in = accum_next;
            groups_in = len_done ? '0 : groups_next;
            if (len_done) begin
               asm_in = '0;
               count_in = ID_BYTES;
               phase_in = PH_ESID;
            end
         end
         PH_ESID: begin
            asm_in = asm_shift;
            count_in = count_dec;
            if (field_done) begin
               es_id_in = asm_shift[15:0];
               phase_in = PH_FLAGS;
            end
         end
         PH_FLAGS: begin
            dep_flag_in = data_byte[7];
            prio_in = data_byte[4:0];
            flags_in = opt_new.flags;
            phase_in = opt_new.phase;
            if (opt_new.start_field) begin
               asm_in = '0;
               count_in = ID_BYTES;
            end
         end
         PH_DEPID, PH_URLSKIP, PH_OCR: begin
            asm_in = asm_shift;
            count_in = count_dec;
            if (field_done) begin
               if (phase_ff == PH_DEPID) begin
                  dep_id_in = asm_shift[15:0];
               end
               flags_in = opt_pending.flags;
               phase_in = opt_pending.phase;
               if (opt_pending.start_field) begin
                  asm_in = '0;
                  count_in = ID_BYTES;
               end
            end
         end
         PH_URLLEN: begin
            count_in = LEN_W'(data_byte);
            if (data_byte == 8'd0) begin
               flags_in = opt_pending.flags;
               phase_in = opt_pending.phase;
               if (opt_pending.start_field) begin
                  asm_in = '0;
                  count_in = ID_BYTES;
               end
            end else begin
               phase_in = PH_URLSKIP;
            end
         end
         PH_TAG4: begin
            if (data_byte != TAG_DEC_CFG) begin
               err_in = ST_TAG4;
               phase_in = PH_DONE;
            end else begin
               accum_in = '0;
               groups_in = '0;
               phase_in = PH_CFGLEN;
            end
         end
         PH_CFGLEN: begin
            accum_in = accum_next;
            groups_in = len_done ? '0 : groups_next;
            if (len_done) begin
               cfg_large_in = (accum_next > CFG_BASE_SIZE);
               phase_in = PH_OBJ;
            end
         end
         PH_OBJ: begin
            obj_in = data_byte;
            phase_in = PH_STYPE;
         end
         PH_STYPE: begin
            stype_in = data_byte[7:2];
            if (!data_byte[0]) begin
               err_in = ST_RESERVED;
               phase_in = PH_DONE;
            end else begin
               asm_in = '0;
               count_in = BUF_BYTES;
               phase_in = PH_BUF;
            end
         end
         PH_BUF: begin
            asm_in = asm_shift;
            count_in = count_dec;
            if (field_done) begin
               buf_in = asm_shift[23:0];
               asm_in = '0;
               count_in = RATE_BYTES;
               phase_in = PH_MAXBR;
            end
         end
         PH_MAXBR: begin
            asm_in = asm_shift;
            count_in = count_dec;
            if (field_done) begin
               maxbr_in = asm_shift;
               asm_in = '0;
               count_in = RATE_BYTES;
               phase_in = PH_AVGBR;
            end
         end
         PH_AVGBR: begin
            asm_in = asm_shift;
            count_in = count_dec;
            if (field_done) begin
               avgbr_in = asm_shift;
               phase_in = cfg_large_ff ? PH_TAG5 : PH_TAG6;
            end
         end
         PH_TAG5: begin
            if (data_byte != TAG_DEC_SPEC) begin
               err_in = ST_TAG5;
               phase_in = PH_DONE;
            end else begin
               accum_in = '0;
               groups_in = '0;
               phase_in = PH_CODLEN;
            end
         end
         PH_CODLEN: begin
            accum_in = accum_next;
            groups_in = len_done ? '0 : groups_next;
            if (len_done) begin
               count_in = accum_next;
               phase_in = (accum_next == '0) ? PH_TAG6 : PH_CODEC;
            end
         end
         PH_CODEC: begin
            count_in = count_dec;
            emit = 1'b1;
            if (field_done) begin
               phase_in = PH_TAG6;
            end
         end
         PH_TAG6: begin
            if (data_byte != TAG_SL) begin
               err_in = ST_TAG6;
               phase_in = PH_DONE;
            end else begin
               accum_in = '0;
               groups_in = '0;
               phase_in = PH_SLLEN;
            end
         end
         PH_SLLEN: begin
            accum_in = accum_next;
            groups_in = len_done ? '0 : groups_next;
            if (len_done) begin
               if (accum_next != SL_LENGTH) begin
                  err_in = ST_SL_LENGTH;
                  phase_in = PH_DONE;
               end else begin
                  phase_in = PH_SLPRE;
               end
            end
         end
         PH_SLPRE: begin
            if (data_byte != SL_PREDEFINED) begin
               err_in = ST_SL_PREDEFINED;
               phase_in = PH_DONE;
            end else begin
               phase_in = PH_DONE;
            end
         end
         default: begin
            phase_in = PH_DONE;
         end
      endcase
   end

   always_comb begin
      result = '0;
      result.valid = advance && (is_last || emit);
      result.kind = is_last;
      if (is_last) begin
         result.es_id = es_id_in;
         result.depends_on_stream = dep_flag_in;
         result.depends_es_id = dep_id_in;
         result.stream_priority = prio_in;
         result.object_type = obj_in;
         result.stream_type = stype_in;
         result.buffer_size = buf_in;
         result.max_bitrate = maxbr_in;
         result.avg_bitrate = avgbr_in;
         if (err_in != ST_OK) begin
            result.status = err_in;
         end else begin
            result.status = (phase_in == PH_DONE) ? ST_OK : ST_TRUNCATED;
         end
      end else begin
         result.codec_byte = data_byte;
      end
   end

   // The byte marked last returns the parser to its reset state.
   always_ff @(posedge clock) begin
      if (reset || (advance && is_last)) begin
         phase_ff <= PH_TAG3;
         count_ff <= '0;
         accum_ff <= '0;
         groups_ff <= '0;
         flags_ff <= '0;
         cfg_large_ff <= 1'b0;
         asm_ff <= '0;
         err_ff <= ST_OK;
         es_id_ff <= '0;
         dep_flag_ff <= 1'b0;
         dep_id_ff <= '0;
         prio_ff <= PRIORITY_RESET;
         obj_ff <= '0;
         stype_ff <= '0;
         buf_ff <= '0;
         maxbr_ff <= '0;
         avgbr_ff <= '0;
      end else if (advance) begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         accum_ff <= accum_in;
         groups_ff <= groups_in;
         flags_ff <= flags_in;
         cfg_large_ff <= cfg_large_in;
         asm_ff <= asm_in;
         err_ff <= err_in;
         es_id_ff <= es_id_in;
         dep_flag_ff <= dep_flag_in;
         dep_id_ff <= dep_id_in;
         prio_ff <= prio_in;
         obj_ff <= obj_in;
         stype_ff <= stype_in;
         buf_ff <= buf_in;
         maxbr_ff <= maxbr_in;
         avgbr_ff <= avgbr_in;
      end
   end

endmodule

FILE: rtl/esdp_rsp_stage.sv
`timescale 1ns / 1ps

module esdp_rsp_stage import esdp_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  result_type result,
   input  logic       rsp_stall,
   output logic       open,
   output logic       rsp_valid,
   output result_type rsp_data
);

   logic       valid_ff;
   result_type data_ff;

   // The stage takes a new request whenever its result can leave or it is empty.
   assign open = !valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (open) begin
         valid_ff <= result.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (open) begin
         data_ff <= result;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data = data_ff;

endmodule

FILE: rtl/es_descriptor_parser_core.sv
`timescale 1ns / 1ps

// Byte-serial parser for an MPEG-4 ES descriptor.
// Request channel: one descriptor byte per request on req_data_byte, with
// req_is_last marking the final byte of the descriptor.
// Response channel: a decoder-specific byte (rsp_kind low) for each byte of
// that section, or a summary (rsp_kind high) with the parsed fields and
// rsp_status on the last byte. Other bytes produce no response.
// Every request is handled by the phase machine as it is accepted, and its
// response, if any, appears in the output register on the next cycle.
// Throughput is one request per cycle while req_stall is low.
// While a response waits under rsp_stall, req_stall is raised; otherwise
// requests are taken every cycle, even with a response sitting in the
// output register that is being taken.
// Reset clears the phase machine and the output valid; the captured fields
// return to zero and the stream priority to 16. The last byte of each
// descriptor returns the parser to the same state.
module es_descriptor_parser_core import esdp_pkg::*; #(
   parameter int MAX_LENGTH_BYTES = MAX_LENGTH_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_is_last,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_kind,
   output logic [7:0]  rsp_codec_byte,
   output logic [15:0] rsp_es_id,
   output logic        rsp_depends_on_stream,
   output logic [15:0] rsp_depends_es_id,
   output logic [4:0]  rsp_stream_priority,
   output logic [7:0]  rsp_object_type,
   output logic [5:0]  rsp_stream_type,
   output logic [23:0] rsp_buffer_size,
   output logic [31:0] rsp_max_bitrate,
   output logic [31:0] rsp_avg_bitrate,
   output logic [3:0]  rsp_status
);

   logic       open;
   logic       advance;
   result_type result;
   result_type rsp_data;

   assign req_stall = !open;
   assign advance = req_valid && open;

   esdp_phase_unit #(
      .MAX_LENGTH_BYTES(MAX_LENGTH_BYTES)
   ) u_phase (
      .clock(clock),
      .reset(reset),
      .advance(advance),
      .data_byte(req_data_byte),
      .is_last(req_is_last),
      .result(result)
   );

   esdp_rsp_stage u_rsp (
      .clock(clock),
      .reset(reset),
      .result(result),
      .rsp_stall(rsp_stall),
      .open(open),
      .rsp_valid(rsp_valid),
      .rsp_data(rsp_data)
   );

   assign rsp_kind = rsp_data.kind;
   assign rsp_codec_byte = rsp_data.codec_byte;
   assign rsp_es_id = rsp_data.es_id;
   assign rsp_depends_on_stream = rsp_data.depends_on_stream;
   assign rsp_depends_es_id = rsp_data.depends_es_id;
   assign rsp_stream_priority = rsp_data.stream_priority;
   assign rsp_object_type = rsp_data.object_type;
   assign rsp_stream_type = rsp_data.stream_type;
   assign rsp_buffer_size = rsp_data.buffer_size;
   assign rsp_max_bitrate = rsp_data.max_bitrate;
   assign rsp_avg_bitrate = rsp_data.avg_bitrate;
   assign rsp_status = rsp_data.status;

endmodule

FILE: rtl/esdp_checker.sv
`timescale 1ns / 1ps
`include "es_descriptor_parser_core_defines.svh"

module esdp_checker import esdp_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        req_is_last,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic        rsp_kind,
   input logic [7:0]  rsp_codec_byte,
   input logic [3:0]  rsp_status
);

   // Requests are held back only by a response that cannot leave.
   `ESDP_ASSERT_NOW(a_stall_cause, clock, reset, req_stall, rsp_valid && rsp_stall, "request stalled without a blocked response")

   // A stalled response keeps its contents.
   `ESDP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_kind) && $stable(rsp_codec_byte) && $stable(rsp_status), "stalled response changed")

   // The last byte of a descriptor always yields a summary on the next cycle.
   `ESDP_ASSERT_NEXT(a_last_summary, clock, reset, req_valid && !req_stall && req_is_last, rsp_valid && rsp_kind, "no summary after the last byte")

   // A decoder-specific byte carries no status.
   `ESDP_ASSERT_NOW(a_data_status, clock, reset, rsp_valid && !rsp_kind, rsp_status == ST_OK, "data response with a status")

endmodule

bind es_descriptor_parser_core esdp_checker u_esdp_checker (
   .clock(clock),
   .reset(reset),
   .req_valid(req_valid),
   .req_stall(req_stall),
   .req_is_last(req_is_last),
   .rsp_valid(rsp_valid),
   .rsp_stall(rsp_stall),
   .rsp_kind(rsp_kind),
   .rsp_codec_byte(rsp_codec_byte),
   .rsp_status(rsp_status)
);
